// ===== rtl/core/nhecc_pkg.sv =====
// Shared types, constants and parity functions of the NAND Hamming ECC engine.
package nhecc_pkg;

  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned BeatW         = 13;
  localparam int unsigned LineW         = 12;
  localparam int unsigned EccW          = 16;
  localparam int unsigned ModeW         = 2;
  localparam int unsigned PageBase      = 512;
  localparam int unsigned LoadSlots     = 4;
  localparam logic [BeatW-1:0] BeatMax  = {BeatW{1'b1}};
  localparam logic [5:0] RecovBase      = 6'd12;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_WORD  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_RECOV = 2'd1,
    ST_ECC   = 2'd2,
    ST_MULTI = 2'd3
  } status_e;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    op_e              op;
    logic [15:0]      data;
    logic [LineW-1:0] line;
    logic             in_page;
    logic             past_hit;
    logic [1:0]       past;
    logic [ModeW-1:0] mode;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic parity8(input logic [7:0] v);
    return ^v;
  endfunction

  function automatic logic [2:0] col_even(input logic [7:0] v);
    return {v[7] ^ v[6] ^ v[5] ^ v[4],
            v[7] ^ v[6] ^ v[3] ^ v[2],
            v[7] ^ v[5] ^ v[3] ^ v[1]};
  endfunction

  function automatic logic [2:0] col_odd(input logic [7:0] v);
    return {v[3] ^ v[2] ^ v[1] ^ v[0],
            v[5] ^ v[4] ^ v[1] ^ v[0],
            v[6] ^ v[4] ^ v[2] ^ v[0]};
  endfunction

  // Counts set bits nibble by nibble and sums the eight partial counts.
  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [5:0] acc;
    logic [2:0] nib;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      nib = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
      acc = acc + 6'(nib);
    end
    return acc;
  endfunction

endpackage

// ===== rtl/core/nhecc_if.sv =====
// Handshake interfaces for the data, configuration and result channels.
interface nhecc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] data;
  modport source (output valid, operation, data, input ready);
  modport sink   (input valid, operation, data, output ready);
endinterface

interface nhecc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] page_mode;
  modport source (output valid, page_mode, input ready);
  modport sink   (input valid, page_mode, output ready);
endinterface

interface nhecc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] parity_syndrome;
  logic [15:0] nparity_syndrome;
  modport source (output valid, status, parity_syndrome, nparity_syndrome, input ready);
  modport sink   (input valid, status, parity_syndrome, nparity_syndrome, output ready);
endinterface

// ===== rtl/core/nhecc_front.sv =====
// Front end: accepts requests, holds page mode and beat count, classifies each beat.
module nhecc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  nhecc_in_if.sink          in_i,
  nhecc_cfg_if.sink         cfg_i,
  input  nhecc_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output nhecc_pkg::cmd_t   cmd_o
);
  import nhecc_pkg::*;

  logic [BeatW-1:0] beat_count_q, beat_count_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic [BeatW-1:0] page_size;
  logic [BeatW-1:0] past_full;
  logic             in_page;
  op_e              op;

  assign in_i.ready  = !q_stat_i.full;
  assign cfg_i.ready = 1'b1;
  assign push_o      = in_i.valid && !q_stat_i.full;
  assign op          = op_e'(in_i.operation);

  assign page_size = BeatW'(PageBase) << mode_q;
  assign in_page   = beat_count_q < page_size;
  assign past_full = beat_count_q - page_size;

  always_comb begin
    cmd_o.op       = op;
    cmd_o.data     = in_i.data;
    cmd_o.line     = beat_count_q[LineW-1:0];
    cmd_o.in_page  = in_page;
    cmd_o.past_hit = !in_page && (past_full < BeatW'(LoadSlots));
    cmd_o.past     = past_full[1:0];
    cmd_o.mode     = mode_q;
  end

  always_comb begin
    beat_count_d = beat_count_q;
    mode_d       = mode_q;
    if (cfg_i.valid) begin
      mode_d = cfg_i.page_mode;
    end
    if (push_o) begin
      case (op)
        OP_BYTE, OP_WORD: begin
          if (beat_count_q != BeatMax) begin
            beat_count_d = beat_count_q + BeatW'(1);
          end
        end
        OP_CLEAR: beat_count_d = '0;
        default:  beat_count_d = beat_count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_count_q <= '0;
      mode_q       <= '0;
    end else begin
      beat_count_q <= beat_count_d;
      mode_q       <= mode_d;
    end
  end

  a_clear_zeroes_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && op == OP_CLEAR) |=> beat_count_q == '0)
    else $error("beat count not cleared");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_o && op == OP_CLEAR) |=> beat_count_q >= $past(beat_count_q))
    else $error("beat count went backward without a clear");

endmodule

// ===== rtl/core/nhecc_queue.sv =====
// Small register queue of classified requests between front and back.
module nhecc_queue #(
  parameter int unsigned Depth = nhecc_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  nhecc_pkg::cmd_t    cmd_i,
  input  logic               pop_i,
  output nhecc_pkg::cmd_t    cmd_o,
  output nhecc_pkg::q_stat_t stat_o
);
  import nhecc_pkg::*;

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  cmd_t            entry_q [Depth];
  logic [IdxW-1:0] wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign stat_o.full  = count_q == CntW'(Depth);
  assign stat_o.empty = count_q == '0;
  assign cmd_o        = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + IdxW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + IdxW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from an empty queue");

endmodule

// ===== rtl/core/nhecc_back.sv =====
// Back end: applies classified beats to the parity state and registers each result.
module nhecc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nhecc_pkg::q_stat_t q_stat_i,
  input  nhecc_pkg::cmd_t    cmd_i,
  output logic               pop_o,
  nhecc_out_if.source        out_o
);
  import nhecc_pkg::*;

  logic [EccW-1:0] calc_p_q, calc_p_d;
  logic [EccW-1:0] calc_np_q, calc_np_d;
  logic [EccW-1:0] read_p_q, read_p_d;
  logic [EccW-1:0] read_np_q, read_np_d;
  logic            out_valid_q;
  status_e         status_q, status_d;
  logic [EccW-1:0] ps_q, nps_q, ps_d, nps_d;
  logic [7:0]      lo, hi;
  logic            p_lo, p_hi, line_hit;
  logic [LineW-1:0] line_mask;
  logic [5:0]      ones;

  assign pop_o = !q_stat_i.empty && (!out_valid_q || out_o.ready);

  assign lo   = cmd_i.data[7:0];
  assign hi   = cmd_i.data[15:8];
  assign p_lo = parity8(lo);
  assign p_hi = parity8(hi);
  assign line_hit  = (cmd_i.op == OP_BYTE) ? p_lo : (p_lo ^ p_hi);
  assign line_mask = {LineW{line_hit}};

  always_comb begin
    calc_p_d  = calc_p_q;
    calc_np_d = calc_np_q;
    read_p_d  = read_p_q;
    read_np_d = read_np_q;
    unique case (cmd_i.op)
      OP_BYTE: begin
        if (cmd_i.in_page) begin
          calc_p_d  = calc_p_q ^ {cmd_i.line & line_mask, 1'b0, col_even(lo)};
          calc_np_d = calc_np_q ^ {~cmd_i.line & line_mask, 1'b0, col_odd(lo)};
        end else if (cmd_i.past_hit) begin
          case (cmd_i.past)
            2'd0:    read_p_d  = {8'h00, lo};
            2'd1:    read_p_d  = {read_p_q[15:8] | lo, read_p_q[7:0]};
            2'd2:    read_np_d = {8'h00, lo};
            default: read_np_d = {read_np_q[15:8] | lo, read_np_q[7:0]};
          endcase
        end
      end
      OP_WORD: begin
        if (cmd_i.in_page) begin
          calc_p_d  = calc_p_q ^
                      {cmd_i.line & line_mask, p_hi, col_even(lo) ^ col_even(hi)};
          calc_np_d = calc_np_q ^
                      {~cmd_i.line & line_mask, p_lo, col_odd(lo) ^ col_odd(hi)};
        end else if (cmd_i.past_hit) begin
          case (cmd_i.past)
            2'd0:    read_p_d  = cmd_i.data;
            2'd1:    read_np_d = cmd_i.data;
            default: read_p_d  = read_p_q;
          endcase
        end
      end
      OP_CLEAR: begin
        calc_p_d  = '0;
        calc_np_d = '0;
        read_p_d  = '0;
        read_np_d = '0;
      end
      OP_NOP: begin
        calc_p_d = calc_p_q;
      end
    endcase
  end

  assign ps_d  = calc_p_d ^ read_p_d;
  assign nps_d = calc_np_d ^ read_np_d;
  assign ones  = popcount32({nps_d, ps_d});

  always_comb begin
    if (ones == '0) begin
      status_d = ST_NONE;
    end else if (ones == 6'd1) begin
      status_d = ST_ECC;
    end else if (ones == RecovBase + 6'(cmd_i.mode)) begin
      status_d = ST_RECOV;
    end else begin
      status_d = ST_MULTI;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calc_p_q    <= '0;
      calc_np_q   <= '0;
      read_p_q    <= '0;
      read_np_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        calc_p_q  <= calc_p_d;
        calc_np_q <= calc_np_d;
        read_p_q  <= read_p_d;
        read_np_q <= read_np_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
      ps_q     <= ps_d;
      nps_q    <= nps_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = status_q;
  assign out_o.parity_syndrome  = ps_q;
  assign out_o.nparity_syndrome = nps_q;

  a_none_means_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_NONE) |-> (ps_q == '0 && nps_q == '0))
    else $error("status none with a nonzero syndrome");

  a_clear_gives_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.op == OP_CLEAR) |=> (out_valid_q && status_q == ST_NONE))
    else $error("clear did not report a clean status");

endmodule

// ===== rtl/core/nand_hamming_ecc_engine.sv =====
// Top level of the NAND flash Hamming ECC generator and checker.
//
//   Channel   Modport   Payload                                       Request moves
//   in_i      sink      operation[1:0], data[15:0]                    one beat, a clear or a no-op
//   cfg_i     sink      page_mode[1:0]                                one page size select
//   out_o     source    status[1:0], parity_syndrome[15:0],           one result per
//                       nparity_syndrome[15:0]                        input request
//
// One request per cycle enters the request queue while in_i.ready is high;
// one result per cycle leaves the result register while out_o.ready is high.
// A stalled result register stops the back end; the front keeps taking requests
// until the two-entry queue fills, at which point in_i.ready drops.
// Reset (rst_ni low, asynchronous) sets page mode to 512-beat pages and clears
// the beat count and all parity words; cfg_i is always ready.
module nand_hamming_ecc_engine #(
  parameter int unsigned QueueDepth = nhecc_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nhecc_in_if.sink    in_i,
  nhecc_cfg_if.sink   cfg_i,
  nhecc_out_if.source out_o
);
  import nhecc_pkg::*;

  // The front owns the page mode and the beat counter, so each beat is tagged
  // with its in-page or past-page position at the moment it is accepted.
  logic    push;
  logic    pop;
  cmd_t    front_cmd;
  cmd_t    back_cmd;
  q_stat_t q_stat;

  nhecc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (front_cmd)
  );

  // The queue decouples classification from the parity update, so a stalled
  // consumer does not immediately stall the flash bus side.
  nhecc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (back_cmd),
    .stat_o (q_stat)
  );

  // The back folds the beat into the parity words, captures stored ECC words,
  // and classifies the 32-bit syndrome into the registered result.
  nhecc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .cmd_i    (back_cmd),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the NAND flash Hamming ECC engine with its own syndrome predictor.
module tb;
  import nhecc_pkg::*;

  // Mirror of the engine state that the predictor steps through.
  typedef struct packed {
    logic [1:0]  mode;
    logic [12:0] beats;
    logic [15:0] rd_par;
    logic [15:0] rd_npar;
    logic [15:0] sum_par;
    logic [15:0] sum_npar;
  } ecc_state_t;

  // One result as the engine reports it.
  typedef struct packed {
    status_e     status;
    logic [15:0] ps;
    logic [15:0] nps;
  } syn_res_t;

  // One row of the directed table. Rows with fixed set carry a hand-typed
  // result; the others are checked against the predictor.
  typedef struct packed {
    logic [1:0]  mode;
    op_e         op;
    logic [15:0] data;
    bit          fixed;
    syn_res_t    res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  nhecc_in_if  in_if ();
  nhecc_cfg_if cfg_if ();
  nhecc_out_if out_if ();

  nand_hamming_ecc_engine u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  ecc_state_t ecc_track;
  syn_res_t   pending_syndromes [$];

  int src_idle_pct  = 36;
  int sink_idle_pct = 78;
  int fault_count     = 0;
  int results_checked = 0;
  int counted_reqs    = 0;
  int excess_beats    = 0;
  int pages_done      = 0;
  int mode_writes     = 0;
  int status_tally [4] = '{0, 0, 0, 0};

  // Directed requests: reset state, data extremes, every operation code,
  // the recoverable threshold at the largest page size, and page size
  // changes in the middle of a page.
  dir_row_t dir_rows [21] = '{
    '{2'd0, OP_NOP,   16'h0000, 1'b1, '{ST_NONE,  16'h0000, 16'h0000}},
    '{2'd0, OP_BYTE,  16'h0000, 1'b1, '{ST_NONE,  16'h0000, 16'h0000}},
    '{2'd0, OP_BYTE,  16'hFFFF, 1'b1, '{ST_NONE,  16'h0000, 16'h0000}},
    '{2'd0, OP_BYTE,  16'hFF01, 1'b0, '0},
    '{2'd0, OP_BYTE,  16'h0080, 1'b0, '0},
    '{2'd0, OP_WORD,  16'hFFFF, 1'b0, '0},
    '{2'd0, OP_WORD,  16'h0001, 1'b0, '0},
    '{2'd0, OP_WORD,  16'h8000, 1'b0, '0},
    '{2'd0, OP_WORD,  16'h0000, 1'b0, '0},
    '{2'd0, OP_CLEAR, 16'h1234, 1'b1, '{ST_NONE,  16'h0000, 16'h0000}},
    '{2'd0, OP_NOP,   16'hFFFF, 1'b1, '{ST_NONE,  16'h0000, 16'h0000}},
    '{2'd3, OP_BYTE,  16'h0001, 1'b1, '{ST_RECOV, 16'h0000, 16'hFFF7}},
    '{2'd3, OP_BYTE,  16'h00FE, 1'b0, '0},
    '{2'd3, OP_WORD,  16'h5AA5, 1'b0, '0},
    '{2'd3, OP_NOP,   16'h0000, 1'b0, '0},
    '{2'd1, OP_BYTE,  16'h0002, 1'b0, '0},
    '{2'd2, OP_WORD,  16'hFF00, 1'b0, '0},
    '{2'd2, OP_WORD,  16'h00FF, 1'b0, '0},
    '{2'd2, OP_CLEAR, 16'h0000, 1'b1, '{ST_NONE,  16'h0000, 16'h0000}},
    '{2'd0, OP_WORD,  16'h0100, 1'b0, '0},
    '{2'd0, OP_CLEAR, 16'hFFFF, 1'b1, '{ST_NONE,  16'h0000, 16'h0000}}
  };

  // Column parity over the odd-weighted and even-weighted bit positions of a byte.
  function automatic logic [2:0] even_cols(input logic [7:0] b);
    return {^(b & 8'hF0), ^(b & 8'hCC), ^(b & 8'hAA)};
  endfunction

  function automatic logic [2:0] odd_cols(input logic [7:0] b);
    return {^(b & 8'h0F), ^(b & 8'h33), ^(b & 8'h55)};
  endfunction

  // Steps the mirror state by one request. Beats inside the page fold into
  // the parity words; the first beats past the page load the stored ECC
  // words; later beats only move the saturating beat count.
  function automatic ecc_state_t ecc_advance(input ecc_state_t s, input op_e op,
                                             input logic [15:0] d);
    ecc_state_t  n;
    logic [12:0] page_beats;
    logic [12:0] past;
    logic [11:0] line_idx;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        line_hit;
    n = s;
    lo = d[7:0];
    hi = d[15:8];
    page_beats = 13'd512 << s.mode;
    past = s.beats - page_beats;
    line_idx = s.beats[11:0];
    if (op == OP_CLEAR) begin
      n = '0;
      n.mode = s.mode;
    end else if (op == OP_BYTE || op == OP_WORD) begin
      if (s.beats != BeatMax) begin
        n.beats = s.beats + 13'd1;
      end
      if (s.beats < page_beats) begin
        if (op == OP_BYTE) begin
          line_hit = ^lo;
          n.sum_par = n.sum_par ^ {13'd0, even_cols(lo)};
          n.sum_npar = n.sum_npar ^ {13'd0, odd_cols(lo)};
        end else begin
          // A word feed also folds each byte's overall parity into bit 3.
          line_hit = (^lo) ^ (^hi);
          n.sum_par = n.sum_par ^ {12'd0, ^hi, even_cols(lo) ^ even_cols(hi)};
          n.sum_npar = n.sum_npar ^ {12'd0, ^lo, odd_cols(lo) ^ odd_cols(hi)};
        end
        if (line_hit) begin
          n.sum_par = n.sum_par ^ {line_idx, 4'd0};
          n.sum_npar = n.sum_npar ^ {~line_idx, 4'd0};
        end
      end else if (op == OP_BYTE) begin
        // The high byte is merged in, so a word load followed by a byte
        // load at the next slot keeps the word's high bits.
        case (past)
          13'd0: n.rd_par = {8'd0, lo};
          13'd1: n.rd_par[15:8] = s.rd_par[15:8] | lo;
          13'd2: n.rd_npar = {8'd0, lo};
          13'd3: n.rd_npar[15:8] = s.rd_npar[15:8] | lo;
          default: ;
        endcase
      end else begin
        if (past == 13'd0) begin
          n.rd_par = d;
        end else if (past == 13'd1) begin
          n.rd_npar = d;
        end
      end
    end
    return n;
  endfunction

  // Classifies the syndrome pair by the number of differing bits.
  function automatic syn_res_t ecc_verdict(input ecc_state_t s);
    syn_res_t r;
    int       ones;
    r.ps = s.sum_par ^ s.rd_par;
    r.nps = s.sum_npar ^ s.rd_npar;
    ones = $countones({r.nps, r.ps});
    if (ones == 0) begin
      r.status = ST_NONE;
    end else if (ones == 1) begin
      r.status = ST_ECC;
    end else if (ones == int'(RecovBase) + int'(s.mode)) begin
      r.status = ST_RECOV;
    end else begin
      r.status = ST_MULTI;
    end
    return r;
  endfunction

  // Offers one request, holding it until the engine takes it, then steps
  // the predictor and queues the result it should produce.
  task automatic send_req(input op_e op, input logic [15:0] d,
                          input bit has_fixed = 1'b0, input syn_res_t fixed = '0);
    logic [12:0] page_beats;
    logic [12:0] past;
    bit          excess;
    @(negedge clk);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.data <= d;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    page_beats = 13'd512 << ecc_track.mode;
    past = ecc_track.beats - page_beats;
    excess = (op == OP_BYTE || op == OP_WORD) && ecc_track.beats >= page_beats &&
             past >= (op == OP_BYTE ? 13'(LoadSlots) : 13'(LoadSlots / 2));
    if (excess) begin
      excess_beats++;
    end else begin
      counted_reqs++;
    end
    ecc_track = ecc_advance(ecc_track, op, d);
    pending_syndromes.push_back(has_fixed ? fixed : ecc_verdict(ecc_track));
  endtask

  task automatic release_in();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  // Waits for every outstanding result, then lets the pipeline settle.
  task automatic drain(input int settle);
    while (pending_syndromes.size() != 0) @(posedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Page size changes happen only with the engine empty.
  task automatic set_page_mode(input logic [1:0] m);
    release_in();
    drain(4);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.page_mode <= m;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    ecc_track.mode = m;
    mode_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // A short burst of mixed requests; partial pages in whatever mode is set.
  task automatic run_noise();
    int          len;
    int          pick;
    op_e         op;
    logic [15:0] d;
    len = $urandom_range(12, 1);
    repeat (len) begin
      pick = $urandom_range(99);
      op = pick < 40 ? OP_BYTE : pick < 75 ? OP_WORD : pick < 87 ? OP_CLEAR : OP_NOP;
      case ($urandom_range(7))
        0: d = 16'h0000;
        1: d = 16'hFFFF;
        default: d = 16'($urandom);
      endcase
      send_req(op, d);
    end
  endtask

  // A complete 512-beat page, its stored ECC words and up to six more beats
  // (in word mode a byte among the first two still loads the nparity word).
  // The stored words come from the clean data, so flipped data bits or a
  // flipped stored bit leave a nonzero syndrome whose weight sets the status.
  task automatic run_page();
    logic [15:0] page_data [512];
    ecc_state_t  clean;
    bit          words;
    int          err_kind;
    logic [15:0] st_par;
    logic [15:0] st_npar;
    logic [31:0] ecc_flip;
    op_e         beat_op;
    words = 1'($urandom_range(1));
    beat_op = words ? OP_WORD : OP_BYTE;
    err_kind = $urandom_range(3);
    set_page_mode(2'd0);
    send_req(OP_CLEAR, 16'($urandom));
    clean = '0;
    for (int i = 0; i < 512; i++) begin
      page_data[i] = 16'($urandom);
      clean = ecc_advance(clean, beat_op, page_data[i]);
    end
    if (err_kind == 1 || err_kind == 2) begin
      page_data[$urandom_range(511)][$urandom_range(words ? 15 : 7)] ^= 1'b1;
    end
    if (err_kind == 2) begin
      page_data[$urandom_range(511)][$urandom_range(words ? 15 : 7)] ^= 1'b1;
    end
    ecc_flip = (err_kind == 3) ? (32'd1 << $urandom_range(31)) : 32'd0;
    st_par = clean.sum_par ^ ecc_flip[15:0];
    st_npar = clean.sum_npar ^ ecc_flip[31:16];
    for (int i = 0; i < 512; i++) begin
      send_req(beat_op, page_data[i]);
    end
    if (words) begin
      send_req(OP_WORD, st_par);
      send_req(OP_WORD, st_npar);
    end else begin
      send_req(OP_BYTE, {8'($urandom), st_par[7:0]});
      send_req(OP_BYTE, {8'($urandom), st_par[15:8]});
      send_req(OP_BYTE, {8'($urandom), st_npar[7:0]});
      send_req(OP_BYTE, {8'($urandom), st_npar[15:8]});
    end
    repeat ($urandom_range(6)) send_req($urandom_range(1) ? OP_WORD : OP_BYTE,
                                        16'($urandom));
    pages_done++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The result side stalls at random with the current idle rate.
  always @(negedge clk) begin
    out_if.ready <= (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
  end

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    syn_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_syndromes.size() == 0) begin
        $error("result arrived with no request outstanding");
        fault_count++;
      end else begin
        want = pending_syndromes.pop_front();
        results_checked++;
        status_tally[want.status]++;
        if (out_if.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_if.status);
          fault_count++;
        end
        if (out_if.parity_syndrome !== want.ps) begin
          $error("parity_syndrome mismatch: expected %h, got %h", want.ps,
                 out_if.parity_syndrome);
          fault_count++;
        end
        if (out_if.nparity_syndrome !== want.nps) begin
          $error("nparity_syndrome mismatch: expected %h, got %h", want.nps,
                 out_if.nparity_syndrome);
          fault_count++;
        end
      end
    end
  end

  // Ends a hung run long after the slowest correct one would finish.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int  phase_start;
    bit  page_done;
    int  roll;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = OP_BYTE;
    in_if.data = 16'h0000;
    cfg_if.valid = 1'b0;
    cfg_if.page_mode = 2'd0;
    out_if.ready = 1'b0;
    ecc_track = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(dir_rows); i++) begin
      if (dir_rows[i].mode != ecc_track.mode) begin
        set_page_mode(dir_rows[i].mode);
      end
      send_req(dir_rows[i].op, dir_rows[i].data, dir_rows[i].fixed, dir_rows[i].res);
    end

    // Three idle profiles: a slow receiver, then a slow sender, then full
    // rate. The full-rate phase also holds one complete page with its stored
    // ECC words. Page size writes in between also make the sender wait for
    // the engine to empty.
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 78 : 0;
      sink_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 36 : 0;
      phase_start = counted_reqs;
      page_done = (ph != 2);
      set_page_mode(2'($urandom_range(3)));
      while (!page_done || counted_reqs - phase_start < 80) begin
        roll = $urandom_range(7);
        if (!page_done && roll == 0) begin
          run_page();
          page_done = 1'b1;
        end else if (roll == 1) begin
          set_page_mode(2'($urandom_range(3)));
        end else begin
          run_noise();
        end
      end
    end

    release_in();
    drain(8);
    $display("Checked %0d results from %0d requests plus %0d excess beats;",
             results_checked, counted_reqs, excess_beats);
    $display("%0d full pages, %0d page size writes; none %0d, recoverable %0d, %s %0d, %s %0d.",
             pages_done, mode_writes, status_tally[ST_NONE], status_tally[ST_RECOV],
             "ECC word", status_tally[ST_ECC], "multiple", status_tally[ST_MULTI]);
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
